/* hdl/sd_pkg.sv */
package sd_pkg;

    localparam int QUEUE_DEPTH     = 4;
    localparam int QUEUE_PTR_BITS  = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_BITS  = $clog2(QUEUE_DEPTH + 1);

    localparam int TIME_BITS       = 32;
    localparam int LIMIT_BITS      = 32;
    localparam int SAMPLE_BITS     = 16;
    localparam int SIGMA_BITS      = 15;
    localparam int EXCESS_BITS     = 16;
    localparam int OUT_INDEX_BITS  = 24;
    localparam int STRIDE_CNT_BITS = 16;

    localparam int LOW_SIGMA_LIMIT = 1024;

    localparam logic [TIME_BITS-1:0] RST_ACCEL_LIMIT = 32'd8192;
    localparam logic [TIME_BITS-1:0] RST_GYRO_LIMIT  = 32'd8192;
    localparam logic [TIME_BITS-1:0] RST_MAX_GAP     = 32'd2000000;
    localparam logic [TIME_BITS-1:0] RST_MIN_GAP     = 32'd220000;

    typedef enum logic [1:0] {
        CFG_ACCEL_LIMIT = 2'd0,
        CFG_GYRO_LIMIT  = 2'd1,
        CFG_MAX_GAP     = 2'd2,
        CFG_MIN_GAP     = 2'd3
    } t_cfg_idx;

    typedef struct packed {
        logic [LIMIT_BITS-1:0] accel_limit;
        logic [LIMIT_BITS-1:0] gyro_limit;
        logic [TIME_BITS-1:0]  max_gap_us;
        logic [TIME_BITS-1:0]  min_gap_us;
    } t_cfg;

    typedef struct packed {
        logic                   block_start;
        logic [TIME_BITS-1:0]   sample_time;
        logic [EXCESS_BITS-1:0] accel_excess;
        logic [EXCESS_BITS-1:0] gyro_excess;
        logic                   low_sigma;
    } t_q_entry;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

endpackage

/* hdl/sd_if.sv */
interface sd_sample_if;
    logic               valid;
    logic               ready;
    logic               block_start;
    logic [31:0]        sample_time;
    logic signed [15:0] accel_y;
    logic signed [15:0] gyro_z;
    logic [14:0]        sigma_accel;
    logic [14:0]        sigma_gyro;

    modport source (
        output valid, block_start, sample_time, accel_y, gyro_z, sigma_accel, sigma_gyro,
        input  ready
    );
    modport sink (
        input  valid, block_start, sample_time, accel_y, gyro_z, sigma_accel, sigma_gyro,
        output ready
    );
endinterface

interface sd_stride_if;
    logic        valid;
    logic        ready;
    logic [23:0] stride_index;
    logic [15:0] stride_number;

    modport source (
        output valid, stride_index, stride_number,
        input  ready
    );
    modport sink (
        input  valid, stride_index, stride_number,
        output ready
    );
endinterface

/* hdl/sd_front.sv */
module sd_front
    import sd_pkg::*;
(
    sd_sample_if.sink  i_sample,
    input  t_q_status  i_q_status,
    output logic       o_push,
    output t_q_entry   o_entry
);

    logic signed [SAMPLE_BITS:0]   accel_diff;
    logic                          accel_hit;
    logic signed [SAMPLE_BITS+2:0] gyro_x5;
    logic signed [SAMPLE_BITS+2:0] sigma_x7_neg;
    logic                          gyro_hit;
    logic signed [SAMPLE_BITS+1:0] gyro_sum;
    logic signed [SAMPLE_BITS+1:0] gyro_neg;
    logic [SIGMA_BITS+2:0]         sigma_a_x5;

    assign i_sample.ready = !i_q_status.full;
    assign o_push         = i_sample.valid && !i_q_status.full;

    always_comb begin
        accel_diff   = (SAMPLE_BITS+1)'(i_sample.accel_y)
                     - $signed({2'b00, i_sample.sigma_accel});
        accel_hit    = !accel_diff[SAMPLE_BITS] && (accel_diff != '0);

        gyro_x5      = ((SAMPLE_BITS+3)'(i_sample.gyro_z) <<< 2)
                     + (SAMPLE_BITS+3)'(i_sample.gyro_z);
        sigma_x7_neg = $signed((SAMPLE_BITS+3)'({i_sample.sigma_gyro, 3'b000}))
                     - $signed((SAMPLE_BITS+3)'(i_sample.sigma_gyro));
        sigma_x7_neg = -sigma_x7_neg;
        gyro_hit     = gyro_x5 < sigma_x7_neg;

        gyro_sum     = (SAMPLE_BITS+2)'(i_sample.gyro_z)
                     + $signed({3'b000, i_sample.sigma_gyro});
        gyro_neg     = -gyro_sum;

        sigma_a_x5   = ({3'b000, i_sample.sigma_accel} << 2) + {3'b000, i_sample.sigma_accel};

        o_entry.block_start  = i_sample.block_start;
        o_entry.sample_time  = i_sample.sample_time;
        o_entry.accel_excess = accel_hit ? accel_diff[EXCESS_BITS-1:0] : '0;
        o_entry.gyro_excess  = gyro_hit ? gyro_neg[EXCESS_BITS-1:0] : '0;
        o_entry.low_sigma    = sigma_a_x5 < (SIGMA_BITS+3)'(LOW_SIGMA_LIMIT);
    end

endmodule

/* hdl/sd_queue.sv */
module sd_queue
    import sd_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_push,
    input  t_q_entry  i_entry,
    input  logic      i_pop,
    output t_q_entry  o_entry,
    output t_q_status o_status
);

    t_q_entry                  r_entry [QUEUE_DEPTH];
    logic [QUEUE_PTR_BITS-1:0] r_wr_ptr, n_wr_ptr;
    logic [QUEUE_PTR_BITS-1:0] r_rd_ptr, n_rd_ptr;
    logic [QUEUE_CNT_BITS-1:0] r_count, n_count;

    assign o_status.full  = (r_count == QUEUE_CNT_BITS'(QUEUE_DEPTH));
    assign o_status.empty = (r_count == '0);
    assign o_entry        = r_entry[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == QUEUE_PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == QUEUE_PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (i_pop && !i_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_entry[r_wr_ptr] <= i_entry;
        end
    end

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= QUEUE_CNT_BITS'(QUEUE_DEPTH))
        else $error("queue count beyond depth");

    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_status.full |-> !i_push)
        else $error("push into full queue");

    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_status.empty |-> !i_pop)
        else $error("pop from empty queue");
`endif

endmodule

/* hdl/sd_back.sv */
module sd_back
    import sd_pkg::*;
#(
    parameter int INDEX_BITS = 24
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cfg        i_cfg,
    input  t_q_status   i_q_status,
    input  t_q_entry    i_entry,
    output logic        o_pop,
    sd_stride_if.source o_stride
);

    logic [LIMIT_BITS-1:0]      r_accel_sum, n_accel_sum;
    logic [LIMIT_BITS-1:0]      r_gyro_sum, n_gyro_sum;
    logic [TIME_BITS-1:0]       r_last_stride, n_last_stride;
    logic [TIME_BITS-1:0]       r_last_trig, n_last_trig;
    logic [INDEX_BITS-1:0]      r_sample_cnt, n_sample_cnt;
    logic [STRIDE_CNT_BITS-1:0] r_stride_cnt, n_stride_cnt;
    logic                       r_out_valid, n_out_valid;
    logic [OUT_INDEX_BITS-1:0]  r_out_index;
    logic [STRIDE_CNT_BITS-1:0] r_out_number;

    logic [LIMIT_BITS-1:0]      base_accel, base_gyro;
    logic [TIME_BITS-1:0]       base_stride_t, base_trig_t;
    logic [INDEX_BITS-1:0]      base_sample;
    logic [STRIDE_CNT_BITS-1:0] base_stride;
    logic [LIMIT_BITS:0]        accel_wide, gyro_wide;
    logic [LIMIT_BITS-1:0]      accel_sat, gyro_sat;
    logic [TIME_BITS-1:0]       gap_stride, gap_trig;
    logic                       trigger, long_gap, reject, emit;
    logic [31:0]                sample_wide;

    assign o_pop           = !i_q_status.empty && (!r_out_valid || o_stride.ready);
    assign o_stride.valid         = r_out_valid;
    assign o_stride.stride_index  = r_out_index;
    assign o_stride.stride_number = r_out_number;

    always_comb begin
        base_accel    = i_entry.block_start ? '0 : r_accel_sum;
        base_gyro     = i_entry.block_start ? '0 : r_gyro_sum;
        base_stride_t = i_entry.block_start ? i_entry.sample_time : r_last_stride;
        base_trig_t   = i_entry.block_start ? i_entry.sample_time : r_last_trig;
        base_sample   = i_entry.block_start ? '0 : r_sample_cnt;
        base_stride   = i_entry.block_start ? '0 : r_stride_cnt;

        accel_wide = {1'b0, base_accel} + (LIMIT_BITS+1)'(i_entry.accel_excess);
        gyro_wide  = {1'b0, base_gyro} + (LIMIT_BITS+1)'(i_entry.gyro_excess);
        accel_sat  = accel_wide[LIMIT_BITS] ? '1 : accel_wide[LIMIT_BITS-1:0];
        gyro_sat   = gyro_wide[LIMIT_BITS] ? '1 : gyro_wide[LIMIT_BITS-1:0];

        gap_stride = i_entry.sample_time - base_stride_t;
        gap_trig   = i_entry.sample_time - base_trig_t;

        trigger  = (gyro_sat > i_cfg.gyro_limit) || (accel_sat > i_cfg.accel_limit);
        long_gap = gap_stride > i_cfg.max_gap_us;
        reject   = (gap_trig < i_cfg.min_gap_us) || i_entry.low_sigma;
        emit     = trigger && !long_gap && !reject;

        sample_wide = 32'(base_sample);

        n_accel_sum   = trigger ? '0 : accel_sat;
        n_gyro_sum    = trigger ? '0 : gyro_sat;
        n_last_trig   = trigger ? i_entry.sample_time : base_trig_t;
        n_last_stride = (trigger && (long_gap || emit)) ? i_entry.sample_time : base_stride_t;
        n_sample_cnt  = base_sample + 1'b1;
        n_stride_cnt  = (emit && (base_stride != '1)) ? base_stride + 1'b1 : base_stride;

        if (o_pop) begin
            n_out_valid = emit;
        end else if (o_stride.ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_accel_sum   <= '0;
            r_gyro_sum    <= '0;
            r_last_stride <= '0;
            r_last_trig   <= '0;
            r_sample_cnt  <= '0;
            r_stride_cnt  <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
            if (o_pop) begin
                r_accel_sum   <= n_accel_sum;
                r_gyro_sum    <= n_gyro_sum;
                r_last_stride <= n_last_stride;
                r_last_trig   <= n_last_trig;
                r_sample_cnt  <= n_sample_cnt;
                r_stride_cnt  <= n_stride_cnt;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop && emit) begin
            r_out_index  <= sample_wide[OUT_INDEX_BITS-1:0];
            r_out_number <= n_stride_cnt;
        end
    end

`ifndef SYNTHESIS
    a_start_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop && i_entry.block_start |=> r_sample_cnt == INDEX_BITS'(1))
        else $error("sample count not restarted");

    a_trigger_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop && trigger |=> (r_accel_sum == '0) && (r_gyro_sum == '0))
        else $error("excess sums not cleared on trigger");

    a_stride_monotonic: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop && !i_entry.block_start |=> r_stride_cnt >= $past(r_stride_cnt))
        else $error("stride count decreased within a run");

    a_emit_number: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop && emit |=> r_out_valid && (r_out_number == r_stride_cnt))
        else $error("emitted stride number differs from count");
`endif

endmodule

/* hdl/stride_detector.sv */
// Stride detector: takes one IMU sample per clock while a queue slot is free, and emits a
// stride transaction when the acceleration or gyro excess sum passes its limit, the timing rule
// accepts it and the low-sigma check passes. Samples enter the four-entry queue between the
// classifying front end and the accumulator back end; the back end retires one queued sample
// per cycle unless the stride output stalls, using a combinational saturating add and limit
// compare. A stride passes the queue and then the output register before it is presented.
// Configuration writes take effect on the next edge and belong between runs.
module stride_detector
    import sd_pkg::*;
#(
    parameter int INDEX_BITS = 24
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [1:0]            i_cfg_idx,
    input  logic [LIMIT_BITS-1:0] i_cfg_data,
    sd_sample_if.sink             i_sample,
    sd_stride_if.source           o_stride
);

    t_cfg      r_cfg;
    t_q_entry  front_entry;
    t_q_entry  queue_entry;
    t_q_status q_status;
    logic      push;
    logic      pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.accel_limit <= RST_ACCEL_LIMIT;
            r_cfg.gyro_limit  <= RST_GYRO_LIMIT;
            r_cfg.max_gap_us  <= RST_MAX_GAP;
            r_cfg.min_gap_us  <= RST_MIN_GAP;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_ACCEL_LIMIT: r_cfg.accel_limit <= i_cfg_data;
                CFG_GYRO_LIMIT:  r_cfg.gyro_limit  <= i_cfg_data;
                CFG_MAX_GAP:     r_cfg.max_gap_us  <= i_cfg_data;
                CFG_MIN_GAP:     r_cfg.min_gap_us  <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    sd_front u_front (
        .i_sample   (i_sample),
        .i_q_status (q_status),
        .o_push     (push),
        .o_entry    (front_entry)
    );

    sd_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_entry  (front_entry),
        .i_pop    (pop),
        .o_entry  (queue_entry),
        .o_status (q_status)
    );

    sd_back #(
        .INDEX_BITS (INDEX_BITS)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (r_cfg),
        .i_q_status (q_status),
        .i_entry    (queue_entry),
        .o_pop      (pop),
        .o_stride   (o_stride)
    );

endmodule
